### rtl/vlmq_pkg.sv
`timescale 1ns / 1ps

package vlmq_pkg;

  localparam int unsigned StoreBytesDef = 4096;
  // buffer_size is 13 bits, so no pointer ever reaches past 8191
  localparam int unsigned MemCap        = 8192;
  localparam int unsigned BsResetMax    = 4096;

  localparam int unsigned OpW   = 3;
  localparam int unsigned LenW  = 12;
  localparam int unsigned OffW  = 12;
  localparam int unsigned ByteW = 8;
  localparam int unsigned BsW   = 13;
  localparam int unsigned StatW = 2;
  localparam int unsigned HlW   = 16;
  // wide enough for pointer + length + header and head + header-derived step
  localparam int unsigned SumW  = 18;

  typedef enum logic [OpW-1:0] {
    OP_ADD    = 3'd0,
    OP_DATA   = 3'd1,
    OP_GET    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_MISUSE  = 2'd2
  } stat_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ADD,
    CMD_ADD_AT0,
    CMD_REFUSE_CLR,
    CMD_RESULT,
    CMD_DATA,
    CMD_CLEAR,
    CMD_HDR_RD,
    CMD_BYTE_RD,
    CMD_GET_ERR,
    CMD_GET_OK,
    CMD_REMOVE,
    CMD_CPY_START,
    CMD_CPY_STEP,
    CMD_CPY_END
  } cmd_e;

  typedef struct packed {
    cmd_e  cmd;
    stat_e stat;
    logic  take;
  } dp_cmd_t;

  typedef struct packed {
    logic add_open;
    logic fits;
    logic fits_zero;
    logic empty;
    logic head_zero;
    logic off_beyond;
    logic copy_done;
  } dp_stat_t;

endpackage

### rtl/vlmq_ctrl.sv
`timescale 1ns / 1ps

module vlmq_ctrl import vlmq_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [OpW-1:0] op_i,
  input  dp_stat_t       stat_i,
  output dp_cmd_t        cmd_o,
  output logic           busy_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HDR  = 5'b00010,
    S_BYTE = 5'b00100,
    S_COPY = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '{cmd: CMD_NONE, stat: ST_OK, take: 1'b0};
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.take = 1'b1;
          op_d       = op_e'(op_i);
          case (op_e'(op_i))
            OP_ADD: begin
              if (stat_i.add_open) begin
                cmd_o.cmd  = CMD_RESULT;
                cmd_o.stat = ST_MISUSE;
              end else if (stat_i.fits) begin
                cmd_o.cmd = CMD_ADD;
              end else if (stat_i.empty) begin
                // compaction of an empty region just rewinds the pointers
                cmd_o.cmd = stat_i.fits_zero ? CMD_ADD_AT0 : CMD_REFUSE_CLR;
              end else if (stat_i.head_zero) begin
                cmd_o.cmd  = CMD_RESULT;
                cmd_o.stat = ST_REFUSED;
              end else begin
                cmd_o.cmd = CMD_CPY_START;
                state_d   = S_COPY;
              end
            end
            OP_DATA: begin
              if (stat_i.add_open) begin
                cmd_o.cmd = CMD_DATA;
              end else begin
                cmd_o.cmd  = CMD_RESULT;
                cmd_o.stat = ST_MISUSE;
              end
            end
            OP_GET, OP_REMOVE: begin
              if (stat_i.empty) begin
                cmd_o.cmd  = CMD_RESULT;
                cmd_o.stat = ST_REFUSED;
              end else begin
                cmd_o.cmd = CMD_HDR_RD;
                state_d   = S_HDR;
              end
            end
            OP_CLEAR: begin
              cmd_o.cmd = CMD_CLEAR;
            end
            default: begin
              cmd_o.cmd  = CMD_RESULT;
              cmd_o.stat = ST_MISUSE;
            end
          endcase
        end
      end
      S_HDR: begin
        if (op_q == OP_GET) begin
          if (stat_i.off_beyond) begin
            cmd_o.cmd = CMD_GET_ERR;
            state_d   = S_IDLE;
          end else begin
            cmd_o.cmd = CMD_BYTE_RD;
            state_d   = S_BYTE;
          end
        end else begin
          cmd_o.cmd = CMD_REMOVE;
          state_d   = S_IDLE;
        end
      end
      S_BYTE: begin
        cmd_o.cmd = CMD_GET_OK;
        state_d   = S_IDLE;
      end
      S_COPY: begin
        if (stat_i.copy_done) begin
          cmd_o.cmd = CMD_CPY_END;
          state_d   = S_FIN;
        end else begin
          cmd_o.cmd = CMD_CPY_STEP;
        end
      end
      S_FIN: begin
        // space test repeated on the compacted region; a refusal keeps it
        if (stat_i.fits) begin
          cmd_o.cmd = CMD_ADD;
        end else begin
          cmd_o.cmd  = CMD_RESULT;
          cmd_o.stat = ST_REFUSED;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_ADD;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

### rtl/vlmq_dp.sv
`timescale 1ns / 1ps

module vlmq_dp import vlmq_pkg::*; #(
  parameter int unsigned STORE_BYTES = StoreBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  input  logic [LenW-1:0]   msg_len_i,
  input  logic [ByteW-1:0]  data_byte_i,
  input  logic [OffW-1:0]   read_offset_i,
  input  logic              cfg_we_i,
  input  logic [BsW-1:0]    cfg_wdata_i,
  output logic              out_valid_o,
  output logic [StatW-1:0]  status_o,
  output logic [LenW-1:0]   head_len_o,
  output logic [ByteW-1:0]  read_byte_o,
  output logic              add_done_o
);

  localparam int unsigned MemDepth = (STORE_BYTES < MemCap) ? STORE_BYTES : MemCap;
  localparam int unsigned AddrW    = $clog2(MemDepth);
  localparam int unsigned PtrW     = AddrW + 1;
  localparam int unsigned WordW    = AddrW - 1;
  localparam int unsigned Words    = (MemDepth + 1) / 2;
  localparam int unsigned BsReset  = (STORE_BYTES < BsResetMax) ? STORE_BYTES : BsResetMax;

  // store kept as 16-bit words split in two byte lanes; records start even
  logic [ByteW-1:0] lo_mem [Words];
  logic [ByteW-1:0] hi_mem [Words];
  logic [ByteW-1:0] lo_rd_q, hi_rd_q;

  logic [PtrW-1:0]  head_q, head_d, tail_q, tail_d, wp_q, wp_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic             add_open_q, add_open_d;
  logic [BsW-1:0]   bs_q;
  logic [WordW-1:0] rd_idx_q, rd_idx_d, wr_idx_q, wr_idx_d;
  logic [AddrW-1:0] rd_left_q, rd_left_d;
  logic             pend_q, pend_d;
  logic             fin_q;

  logic [LenW-1:0]  len_q, hl_q;
  logic [OffW-1:0]  off_q;
  logic             sel_hi_q;

  logic             res_valid_q, res_valid_d;
  stat_e            res_stat_q, res_stat_d;
  logic [LenW-1:0]  res_hl_q, res_hl_d;
  logic [ByteW-1:0] res_rb_q, res_rb_d;
  logic             res_done_q, res_done_d;

  logic [LenW-1:0]  cur_len;
  logic             len_zero;
  logic [SumW-1:0]  eff, byte_addr, step, next_head;
  logic [HlW-1:0]   hl_full;
  logic [PtrW-1:0]  wp_plus2, span;

  logic [WordW-1:0] rd_word, wr_word;
  logic             we_lo, we_hi;
  logic [ByteW-1:0] wr_lo, wr_hi;

  // the space test repeated after compaction uses the latched length
  assign cur_len   = fin_q ? len_q : msg_len_i;
  assign len_zero  = (cur_len == '0);
  assign eff       = (SumW'(bs_q) < SumW'(STORE_BYTES)) ? SumW'(bs_q) : SumW'(STORE_BYTES);
  assign hl_full   = {hi_rd_q, lo_rd_q};
  assign byte_addr = SumW'(head_q) + SumW'(off_q) + SumW'(2);
  assign step      = (SumW'(hl_full) + SumW'(3)) & ~SumW'(1);
  assign next_head = SumW'(head_q) + step;
  assign wp_plus2  = wp_q + PtrW'(2);
  assign span      = tail_q - head_q;

  assign stat_o.add_open   = add_open_q;
  assign stat_o.fits       = (SumW'(tail_q) + SumW'(cur_len) + SumW'(2)) < eff;
  assign stat_o.fits_zero  = (SumW'(cur_len) + SumW'(2)) < eff;
  assign stat_o.empty      = (head_q >= tail_q);
  assign stat_o.head_zero  = (head_q == '0);
  assign stat_o.off_beyond = (HlW'(off_q) >= hl_full);
  assign stat_o.copy_done  = (rd_left_q == '0) && !pend_q;

  always_comb begin
    rd_word = head_q[AddrW-1:1];
    case (cmd_i.cmd)
      CMD_BYTE_RD:  rd_word = byte_addr[AddrW-1:1];
      CMD_CPY_STEP: rd_word = rd_idx_q;
      default:      rd_word = head_q[AddrW-1:1];
    endcase
  end

  always_comb begin
    we_lo   = 1'b0;
    we_hi   = 1'b0;
    wr_word = tail_q[AddrW-1:1];
    wr_lo   = cur_len[ByteW-1:0];
    wr_hi   = ByteW'(cur_len[LenW-1:ByteW]);
    case (cmd_i.cmd)
      CMD_ADD: begin
        we_lo = 1'b1;
        we_hi = 1'b1;
      end
      CMD_ADD_AT0: begin
        wr_word = '0;
        we_lo   = 1'b1;
        we_hi   = 1'b1;
      end
      CMD_DATA: begin
        wr_word = wp_q[AddrW-1:1];
        wr_lo   = data_byte_i;
        wr_hi   = data_byte_i;
        we_lo   = !wp_q[0];
        we_hi   = wp_q[0];
      end
      CMD_CPY_STEP: begin
        wr_word = wr_idx_q;
        wr_lo   = lo_rd_q;
        wr_hi   = hi_rd_q;
        we_lo   = pend_q;
        we_hi   = pend_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    lo_rd_q <= lo_mem[rd_word];
    hi_rd_q <= hi_mem[rd_word];
    if (we_lo) lo_mem[wr_word] <= wr_lo;
    if (we_hi) hi_mem[wr_word] <= wr_hi;
  end

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    wp_d        = wp_q;
    rem_d       = rem_q;
    add_open_d  = add_open_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    rd_left_d   = rd_left_q;
    pend_d      = pend_q;
    res_valid_d = 1'b0;
    res_stat_d  = ST_OK;
    res_hl_d    = '0;
    res_rb_d    = '0;
    res_done_d  = 1'b0;
    case (cmd_i.cmd)
      CMD_ADD: begin
        wp_d        = tail_q + PtrW'(2);
        rem_d       = cur_len;
        res_valid_d = 1'b1;
        if (len_zero) begin
          tail_d     = tail_q + PtrW'(2);
          res_done_d = 1'b1;
        end else begin
          add_open_d = 1'b1;
        end
      end
      CMD_ADD_AT0: begin
        head_d      = '0;
        wp_d        = PtrW'(2);
        rem_d       = cur_len;
        res_valid_d = 1'b1;
        if (len_zero) begin
          tail_d     = PtrW'(2);
          res_done_d = 1'b1;
        end else begin
          tail_d     = '0;
          add_open_d = 1'b1;
        end
      end
      CMD_REFUSE_CLR: begin
        head_d      = '0;
        tail_d      = '0;
        res_valid_d = 1'b1;
        res_stat_d  = ST_REFUSED;
      end
      CMD_RESULT: begin
        res_valid_d = 1'b1;
        res_stat_d  = cmd_i.stat;
      end
      CMD_DATA: begin
        wp_d        = wp_q + PtrW'(1);
        rem_d       = rem_q - LenW'(1);
        res_valid_d = 1'b1;
        if (rem_q == LenW'(1)) begin
          // commit: tail moves to the next even address
          tail_d     = {wp_plus2[PtrW-1:1], 1'b0};
          add_open_d = 1'b0;
          res_done_d = 1'b1;
        end
      end
      CMD_CLEAR: begin
        head_d      = '0;
        tail_d      = '0;
        wp_d        = '0;
        rem_d       = '0;
        add_open_d  = 1'b0;
        res_valid_d = 1'b1;
      end
      CMD_GET_ERR: begin
        res_valid_d = 1'b1;
        res_stat_d  = ST_MISUSE;
        res_hl_d    = hl_full[LenW-1:0];
      end
      CMD_GET_OK: begin
        res_valid_d = 1'b1;
        res_hl_d    = hl_q;
        res_rb_d    = sel_hi_q ? hi_rd_q : lo_rd_q;
      end
      CMD_REMOVE: begin
        res_valid_d = 1'b1;
        if (next_head >= SumW'(tail_q)) begin
          // reached the tail; rewind unless an add is still filling
          if (add_open_q) begin
            head_d = tail_q;
          end else begin
            head_d = '0;
            tail_d = '0;
          end
        end else begin
          head_d = next_head[PtrW-1:0];
        end
      end
      CMD_CPY_START: begin
        rd_idx_d  = head_q[AddrW-1:1];
        rd_left_d = span[PtrW-1:1];
        wr_idx_d  = '0;
        pend_d    = 1'b0;
      end
      CMD_CPY_STEP: begin
        if (rd_left_q != '0) begin
          rd_idx_d  = rd_idx_q + WordW'(1);
          rd_left_d = rd_left_q - AddrW'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) wr_idx_d = wr_idx_q + WordW'(1);
      end
      CMD_CPY_END: begin
        tail_d = span;
        head_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      wp_q        <= '0;
      rem_q       <= '0;
      add_open_q  <= 1'b0;
      bs_q        <= BsW'(BsReset);
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      rd_left_q   <= '0;
      pend_q      <= 1'b0;
      fin_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      wp_q        <= wp_d;
      rem_q       <= rem_d;
      add_open_q  <= add_open_d;
      rd_idx_q    <= rd_idx_d;
      wr_idx_q    <= wr_idx_d;
      rd_left_q   <= rd_left_d;
      pend_q      <= pend_d;
      fin_q       <= (cmd_i.cmd == CMD_CPY_END);
      res_valid_q <= res_valid_d;
      if (cfg_we_i) bs_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      len_q <= msg_len_i;
      off_q <= read_offset_i;
    end
    if (cmd_i.cmd == CMD_BYTE_RD) begin
      hl_q     <= hl_full[LenW-1:0];
      sel_hi_q <= byte_addr[0];
    end
    if (res_valid_d) begin
      res_stat_q <= res_stat_d;
      res_hl_q   <= res_hl_d;
      res_rb_q   <= res_rb_d;
      res_done_q <= res_done_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign status_o    = res_stat_q;
  assign head_len_o  = res_hl_q;
  assign read_byte_o = res_rb_q;
  assign add_done_o  = res_done_q;

  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("head pointer passed tail pointer");

  a_ptrs_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_q[0] && !tail_q[0])
    else $error("record pointer not even");

  a_open_has_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_open_q |-> (rem_q != '0))
    else $error("add open with no bytes remaining");

  a_open_wp_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_open_q |-> (wp_q > tail_q))
    else $error("write pointer not ahead of tail during add");

endmodule

### rtl/variable_length_message_queue_core.sv
`timescale 1ns / 1ps

// Length-prefixed message queue over a 16-bit-wide byte store. A request is
// taken when start is high and busy is low; its single result appears on the
// result ports for exactly one cycle with out_valid_o high, and the receiver
// cannot stall it. Data byte, remove all, a begin add that moves no data and
// every refused or misuse request not named below leave busy low, so they can
// be issued back to back. Remove one passes through a header read. Get head
// reads the header, then the payload byte, through the single registered read
// port of the store, and skips the payload read when the offset is at or
// beyond the length. A begin add that needs compaction moves the live region
// down to address 0, one 16-bit word per cycle, before it fits or is refused.
// No clearing pass after reset.
module variable_length_message_queue_core import vlmq_pkg::*; #(
  parameter int unsigned STORE_BYTES = StoreBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [OpW-1:0]    op_i,
  input  logic [LenW-1:0]   msg_len_i,
  input  logic [ByteW-1:0]  data_byte_i,
  input  logic [OffW-1:0]   read_offset_i,
  input  logic              cfg_we_i,
  input  logic [BsW-1:0]    cfg_wdata_i,
  output logic              out_valid_o,
  output logic [StatW-1:0]  status_o,
  output logic [LenW-1:0]   head_len_o,
  output logic [ByteW-1:0]  read_byte_o,
  output logic              add_done_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  vlmq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (op_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  vlmq_dp #(
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .msg_len_i     (msg_len_i),
    .data_byte_i   (data_byte_i),
    .read_offset_i (read_offset_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .head_len_o    (head_len_o),
    .read_byte_o   (read_byte_o),
    .add_done_o    (add_done_o)
  );

endmodule

### test/tb_variable_length_message_queue_core.sv
`timescale 1ns / 1ps

module tb_variable_length_message_queue_core;
  import vlmq_pkg::*;

  localparam int unsigned STORE = StoreBytesDef;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 255;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [OpW-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OpW-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OpW-1:0] OP_SPARE_7 = 3'd7;

  typedef enum logic [1:0] {
    ITEM_REQ,
    ITEM_CFG,
    ITEM_DRAIN
  } item_kind_e;

  typedef struct {
    item_kind_e        kind;
    logic [OpW-1:0]    op;
    logic [LenW-1:0]   len;
    logic [ByteW-1:0]  db;
    logic [OffW-1:0]   off;
    logic [BsW-1:0]    size;
    int unsigned       idle_pct;
  } stim_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [LenW-1:0]  head_len;
    logic [ByteW-1:0] read_byte;
    logic             add_done;
  } reply_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [OpW-1:0]    op_i = '0;
  logic [LenW-1:0]   msg_len_i = '0;
  logic [ByteW-1:0]  data_byte_i = '0;
  logic [OffW-1:0]   read_offset_i = '0;
  logic              cfg_we_i = 1'b0;
  logic [BsW-1:0]    cfg_wdata_i = '0;
  logic              out_valid_o;
  logic [StatW-1:0]  status_o;
  logic [LenW-1:0]   head_len_o;
  logic [ByteW-1:0]  read_byte_o;
  logic              add_done_o;

  stim_t       pending[$];
  reply_t      expected_replies[$];
  reply_t      want;
  int unsigned gen_idle_pct;
  int unsigned requests_sent;
  int unsigned replies_seen;
  int unsigned mismatches;
  int unsigned stall_cycles;
  int unsigned gap_left;
  int unsigned settle_cnt;
  int unsigned cur_idle_pct;

  // queue shadow
  logic [ByteW-1:0] mq_store [STORE];
  int unsigned      mq_head, mq_tail, mq_wr, mq_left, mq_size;
  bit               mq_open;

  variable_length_message_queue_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .msg_len_i    (msg_len_i),
    .data_byte_i  (data_byte_i),
    .read_offset_i(read_offset_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .head_len_o   (head_len_o),
    .read_byte_o  (read_byte_o),
    .add_done_o   (add_done_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Applies one request to the shadow queue and returns the reply it must give.
  function automatic reply_t queue_reply(logic [OpW-1:0] op, logic [LenW-1:0] len,
                                         logic [ByteW-1:0] db, logic [OffW-1:0] off);
    reply_t      r;
    int unsigned lim, hl, i;
    r = '0;
    lim = (mq_size < STORE) ? mq_size : STORE;
    case (op)
      OP_ADD: begin
        if (mq_open) begin
          r.status = ST_MISUSE;
        end else begin
          if (mq_tail + len + 2 >= lim) begin
            // slide the live region down to address 0
            if (mq_head > 0 && mq_tail > mq_head && mq_tail <= STORE) begin
              for (i = 0; i < mq_tail - mq_head; i++) mq_store[i] = mq_store[mq_head + i];
              mq_tail = mq_tail - mq_head;
              mq_head = 0;
            end else if (mq_head >= mq_tail) begin
              mq_head = 0;
              mq_tail = 0;
            end
          end
          if (mq_tail + len + 2 >= lim) begin
            r.status = ST_REFUSED;
          end else begin
            mq_store[mq_tail] = len[7:0];
            mq_store[mq_tail + 1] = {4'b0, len[11:8]};
            mq_wr = mq_tail + 2;
            mq_left = len;
            if (len == 0) begin
              mq_tail = mq_tail + 2;
              r.add_done = 1'b1;
            end else begin
              mq_open = 1'b1;
            end
          end
        end
      end
      OP_DATA: begin
        if (!mq_open) begin
          r.status = ST_MISUSE;
        end else begin
          mq_store[mq_wr] = db;
          mq_wr = mq_wr + 1;
          mq_left = mq_left - 1;
          if (mq_left == 0) begin
            mq_tail = (mq_wr + 1) & ~32'd1;
            mq_open = 1'b0;
            r.add_done = 1'b1;
          end
        end
      end
      OP_GET: begin
        if (mq_head >= mq_tail) begin
          r.status = ST_REFUSED;
        end else begin
          hl = {mq_store[mq_head + 1], mq_store[mq_head]};
          r.head_len = hl[LenW-1:0];
          if (off >= hl) r.status = ST_MISUSE;
          else r.read_byte = mq_store[mq_head + 2 + off];
        end
      end
      OP_REMOVE: begin
        if (mq_head >= mq_tail) begin
          r.status = ST_REFUSED;
        end else begin
          hl = {mq_store[mq_head + 1], mq_store[mq_head]};
          mq_head = mq_head + ((hl + 3) & ~32'd1);
          if (mq_head > mq_tail) mq_head = mq_tail;
          // pointer rewind is held off while an add is still filling
          if (mq_head == mq_tail && !mq_open) begin
            mq_head = 0;
            mq_tail = 0;
          end
        end
      end
      OP_CLEAR: begin
        mq_head = 0;
        mq_tail = 0;
        mq_open = 1'b0;
        mq_left = 0;
        mq_wr = 0;
      end
      default: r.status = ST_MISUSE;
    endcase
    return r;
  endfunction

  task automatic push_req(logic [OpW-1:0] op, int unsigned len, int unsigned db,
                          int unsigned off);
    stim_t s;
    s.kind = ITEM_REQ;
    s.op = op;
    s.len = len[LenW-1:0];
    s.db = db[ByteW-1:0];
    s.off = off[OffW-1:0];
    s.size = '0;
    s.idle_pct = gen_idle_pct;
    pending.push_back(s);
  endtask

  task automatic push_ctl(item_kind_e kind, int unsigned size);
    stim_t s;
    s.kind = kind;
    s.op = OP_CLEAR;
    s.len = '0;
    s.db = '0;
    s.off = '0;
    s.size = size[BsW-1:0];
    s.idle_pct = 0;
    pending.push_back(s);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : drive
    stim_t nxt;
    logic  launch, we;
    if (!rst_ni) begin
      start <= 1'b0;
      cfg_we_i <= 1'b0;
      requests_sent = 0;
      gap_left = 0;
      settle_cnt = 0;
      cur_idle_pct = 0;
    end else begin
      launch = 1'b0;
      we = 1'b0;
      if (start && !busy) begin
        requests_sent++;
        if ($urandom_range(0, 99) < cur_idle_pct) gap_left = $urandom_range(1, 10);
      end
      if (start && busy) begin
        launch = 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
      end else if (pending.size() != 0) begin
        if (pending[0].kind == ITEM_REQ) begin
          nxt = pending.pop_front();
          launch = 1'b1;
          cur_idle_pct = nxt.idle_pct;
          op_i <= nxt.op;
          msg_len_i <= nxt.len;
          data_byte_i <= nxt.db;
          read_offset_i <= nxt.off;
        end else if (replies_seen >= requests_sent) begin
          // queue drained: let the block settle before touching the register
          if (settle_cnt < SETTLE_CYCLES) begin
            settle_cnt++;
          end else begin
            settle_cnt = 0;
            nxt = pending.pop_front();
            if (nxt.kind == ITEM_CFG) begin
              we = 1'b1;
              cfg_wdata_i <= nxt.size;
            end
          end
        end
      end
      start <= launch;
      cfg_we_i <= we;
    end
  end

  // reply checker and shadow update, both from what is seen on the ports
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (mq_store[i]) mq_store[i] = '0;
      mq_head = 0;
      mq_tail = 0;
      mq_wr = 0;
      mq_left = 0;
      mq_open = 1'b0;
      mq_size = (StoreBytesDef < BsResetMax) ? StoreBytesDef : BsResetMax;
      replies_seen <= 0;
    end else begin
      if (out_valid_o) begin
        replies_seen <= replies_seen + 1;
        if (expected_replies.size() == 0) begin
          $error("reply with no request outstanding");
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatches++;
          end
          if (head_len_o !== want.head_len) begin
            $error("head_len: expected %0d, got %0d", want.head_len, head_len_o);
            mismatches++;
          end
          if (read_byte_o !== want.read_byte) begin
            $error("read_byte: expected %0d, got %0d", want.read_byte, read_byte_o);
            mismatches++;
          end
          if (add_done_o !== want.add_done) begin
            $error("add_done: expected %0d, got %0d", want.add_done, add_done_o);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) mq_size = cfg_wdata_i;
      if (start && !busy)
        expected_replies.push_back(queue_reply(op_i, msg_len_i, data_byte_i, read_offset_i));
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || out_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned p, n, len, k, roll, bs, cap, short_cap, noise;
    int unsigned phase_size [NUM_PHASES];
    int unsigned phase_idle [NUM_PHASES];
    phase_size = '{4, 37, 128, 0, 1000, 4096};
    phase_idle = '{25, 8, 40, 15, 30, 0};
    mismatches = 0;
    stall_cycles = 0;

    // directed opening, buffer at its reset size
    gen_idle_pct = 20;
    push_req(OP_GET, 0, 0, 0);
    push_req(OP_REMOVE, 0, 0, 0);
    push_req(OP_DATA, 0, 8'hff, 0);
    push_req(OP_SPARE_5, 0, 0, 0);
    push_req(OP_SPARE_6, 0, 0, 0);
    push_req(OP_SPARE_7, 0, 0, 0);
    push_req(OP_ADD, 0, 0, 0);          // empty message completes at once
    push_req(OP_ADD, 3, 0, 0);
    push_req(OP_ADD, 1, 0, 0);          // add already open
    push_req(OP_DATA, 0, 8'ha5, 0);
    push_req(OP_DATA, 0, 8'h5a, 0);
    push_req(OP_DATA, 0, 8'hff, 0);
    push_req(OP_GET, 0, 0, 2);          // head is empty: offset beyond length
    push_req(OP_REMOVE, 0, 0, 0);
    push_req(OP_GET, 0, 0, 2);
    push_req(OP_GET, 0, 0, 4093);
    push_req(OP_ADD, 1, 0, 0);
    push_req(OP_REMOVE, 0, 0, 0);       // head meets tail with an add open
    push_req(OP_DATA, 0, 8'h00, 0);
    push_req(OP_GET, 0, 0, 0);
    push_req(OP_ADD, 4093, 0, 0);       // compacts, still refused
    push_req(OP_CLEAR, 0, 0, 0);
    push_req(OP_ADD, 4093, 0, 0);
    push_req(OP_CLEAR, 0, 0, 0);        // abandons the open add
    push_req(OP_GET, 0, 0, 0);

    for (p = 0; p < NUM_PHASES; p++) begin
      bs = (phase_size[p] == 0) ? $urandom_range(4, 4096) : phase_size[p];
      gen_idle_pct = phase_idle[p];
      push_ctl(ITEM_CFG, bs);
      cap = (bs > 303) ? 300 : bs - 3;
      short_cap = (bs / 8 + 1 < 16) ? bs / 8 + 1 : 16;
      if (short_cap > cap) short_cap = cap;
      n = 0;
      while (n < PHASE_ITEMS) begin
        if (n >= PHASE_ITEMS / 2 && n < PHASE_ITEMS / 2 + 8) begin
          push_ctl(ITEM_DRAIN, 0);
          n = n + 8;
        end
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
          len = ($urandom_range(0, 99) < 80) ? $urandom_range(0, short_cap)
                                              : $urandom_range(0, cap);
          push_req(OP_ADD, len, 0, 0);
          for (k = 0; k < len; k++) push_req(OP_DATA, 0, $urandom_range(0, 255), 0);
          n = n + len + 1;
        end else if (roll < 68) begin
          roll = $urandom_range(0, 99);
          push_req(OP_GET, 0, 0, (roll < 70) ? $urandom_range(0, 15) :
                                 (roll < 85) ? $urandom_range(0, 300) :
                                               $urandom_range(0, 4093));
          n++;
        end else if (roll < 84) begin
          push_req(OP_REMOVE, 0, 0, 0);
          n++;
        end else if (roll < 87) begin
          push_req(OP_CLEAR, 0, 0, 0);
          n++;
        end else if (roll < 93) begin
          // add cut short by another request
          len = $urandom_range(0, 4093);
          k = $urandom_range(0, (len < 8) ? len : 8);
          push_req(OP_ADD, len, 0, 0);
          for (int j = 0; j < k; j++) push_req(OP_DATA, 0, $urandom_range(0, 255), 0);
          noise = $urandom_range(OP_ADD, OP_CLEAR);
          push_req(OpW'(noise), $urandom_range(0, 4093), 0, $urandom_range(0, 15));
          n = n + k + 2;
          if (len - k <= 16) begin
            for (int j = k; j < len; j++) push_req(OP_DATA, 0, $urandom_range(0, 255), 0);
            n = n + len - k;
          end else begin
            push_req(OP_CLEAR, 0, 0, 0);
            n++;
          end
        end else begin
          push_req(OpW'($urandom_range(0, (1 << OpW) - 1)), $urandom_range(0, 4093),
                   $urandom_range(0, 255), $urandom_range(0, 4093));
          n++;
        end
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (pending.size() != 0 || start || replies_seen < requests_sent) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (expected_replies.size() != 0) begin
      $error("%0d replies never arrived", expected_replies.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
rtl/vlmq_pkg.sv
rtl/vlmq_ctrl.sv
rtl/vlmq_dp.sv
rtl/variable_length_message_queue_core.sv
test/tb_variable_length_message_queue_core.sv
